>>> hw/rtl/dtq_pkg.sv
`timescale 1ns / 1ps

package dtq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_TICK = 2'd1,
        OP_POP  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_WR,
        S_FIX_WR,
        S_TICK_CHK,
        S_POP_CHK,
        S_UP_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_dtq_cmd;

    typedef struct packed {
        logic    idle;
        logic    done;
        t_status status;
        logic    found;
    } t_dtq_rsp;

endpackage

>>> hw/rtl/dtq_engine.sv
`timescale 1ns / 1ps

module dtq_engine
    import dtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TICK_BITS   = 32,
    parameter int ID_BITS     = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dtq_cmd             i_cmd,
    input  logic [ID_BITS-1:0]   i_id,
    input  logic [TICK_BITS-1:0] i_ticks,
    input  logic                 i_out_free,
    output t_dtq_rsp             o_rsp,
    output logic [ID_BITS-1:0]   o_thread
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = ID_BITS + TICK_BITS;

    // Each slot holds {thread, delta}.
    logic [EW-1:0] r_mem [QUEUE_DEPTH];
    logic [EW-1:0] r_rd;

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [ID_BITS-1:0]   r_id, n_id;
    logic [TICK_BITS-1:0] r_want, n_want;
    logic [TICK_BITS-1:0] r_sum, n_sum;
    logic [TICK_BITS-1:0] r_newd, n_newd;
    logic [IW-1:0]        r_pos, n_pos;
    logic [IW-1:0]        r_k, n_k;
    logic [CW-1:0]        r_count, n_count;
    t_status              r_status, n_status;
    logic                 r_found, n_found;
    logic [ID_BITS-1:0]   r_got, n_got;

    logic [IW-1:0]        rd_addr;
    logic                 we;
    logic [IW-1:0]        wa;
    logic [EW-1:0]        wd;

    logic [TICK_BITS-1:0] au_a, au_b, au_y;
    logic                 au_sub;

    logic [ID_BITS-1:0]   rd_id;
    logic [TICK_BITS-1:0] rd_delta;

    assign rd_id    = r_rd[EW-1:TICK_BITS];
    assign rd_delta = r_rd[TICK_BITS-1:0];

    // The one adder, shared by the push and tick steps.
    assign au_y = au_sub ? (au_a - au_b) : (au_a + au_b);

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_op     <= n_op;
        r_id     <= n_id;
        r_want   <= n_want;
        r_sum    <= n_sum;
        r_newd   <= n_newd;
        r_pos    <= n_pos;
        r_k      <= n_k;
        r_status <= n_status;
        r_found  <= n_found;
        r_got    <= n_got;
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_id     = r_id;
        n_want   = r_want;
        n_sum    = r_sum;
        n_newd   = r_newd;
        n_pos    = r_pos;
        n_k      = r_k;
        n_count  = r_count;
        n_status = r_status;
        n_found  = r_found;
        n_got    = r_got;
        rd_addr  = '0;
        we       = 1'b0;
        wa       = r_pos;
        wd       = r_rd;
        au_a     = r_sum;
        au_b     = rd_delta;
        au_sub   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_op     = i_cmd.op;
                    n_id     = i_id;
                    n_want   = i_ticks;
                    n_sum    = '0;
                    n_pos    = '0;
                    n_k      = '0;
                    n_status = ST_DONE;
                    n_found  = 1'b0;
                    n_got    = '0;
                    case (i_cmd.op)
                        OP_PUSH: begin
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else if (r_count == '0) begin
                                n_state = S_INS_WR;
                            end else begin
                                n_state = S_PUSH_CMP;
                            end
                        end
                        OP_TICK: begin
                            n_state = (r_count == '0) ? S_DONE : S_TICK_CHK;
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_NONE;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_POP_CHK;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Walk the list one slot a cycle, keeping the running total.
            S_PUSH_CMP: begin
                if (r_want < au_y) begin
                    n_k     = r_count[IW-1:0];
                    n_state = S_SHIFT_RD;
                end else begin
                    n_sum = au_y;
                    n_pos = r_pos + IW'(1);
                    if (CW'(r_pos) + CW'(1) == r_count) begin
                        n_state = S_INS_WR;
                    end else begin
                        rd_addr = r_pos + IW'(1);
                    end
                end
            end

            S_SHIFT_RD: begin
                rd_addr = r_k - IW'(1);
                n_state = S_SHIFT_WR;
            end

            // Move the tail up by one slot, from the end toward the insert point.
            S_SHIFT_WR: begin
                we  = 1'b1;
                wa  = r_k;
                n_k = r_k - IW'(1);
                if ((r_k - IW'(1)) > r_pos) begin
                    rd_addr = r_k - IW'(2);
                end else begin
                    n_state = S_INS_WR;
                end
            end

            S_INS_WR: begin
                au_a    = r_want;
                au_b    = r_sum;
                au_sub  = 1'b1;
                we      = 1'b1;
                wa      = r_pos;
                wd      = {r_id, au_y};
                n_newd  = au_y;
                n_count = r_count + CW'(1);
                if (CW'(r_pos) < r_count) begin
                    rd_addr = r_pos + IW'(1);
                    n_state = S_FIX_WR;
                end else begin
                    n_state = S_DONE;
                end
            end

            // The entry behind the new one now waits relative to it.
            S_FIX_WR: begin
                au_a    = rd_delta;
                au_b    = r_newd;
                au_sub  = 1'b1;
                we      = 1'b1;
                wa      = r_pos + IW'(1);
                wd      = {rd_id, au_y};
                n_state = S_DONE;
            end

            S_TICK_CHK: begin
                au_a   = rd_delta;
                au_b   = TICK_BITS'(1);
                au_sub = 1'b1;
                if (rd_delta != '0) begin
                    we      = 1'b1;
                    wa      = r_k;
                    wd      = {rd_id, au_y};
                    n_state = S_DONE;
                end else if (CW'(r_k) + CW'(1) == r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_k     = r_k + IW'(1);
                    rd_addr = r_k + IW'(1);
                end
            end

            S_POP_CHK: begin
                if (rd_delta != '0) begin
                    n_status = ST_NONE;
                    n_state  = S_DONE;
                end else begin
                    n_found = 1'b1;
                    n_got   = rd_id;
                    n_count = r_count - CW'(1);
                    if (r_count > CW'(1)) begin
                        n_k     = IW'(1);
                        rd_addr = IW'(1);
                        n_state = S_UP_WR;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            // Close the gap at the front; the count is already reduced here.
            S_UP_WR: begin
                we = 1'b1;
                wa = r_k - IW'(1);
                if (CW'(r_k) < r_count) begin
                    n_k     = r_k + IW'(1);
                    rd_addr = r_k + IW'(1);
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    assign o_rsp.idle   = (r_state == S_IDLE);
    assign o_rsp.done   = (r_state == S_DONE);
    assign o_rsp.status = r_status;
    assign o_rsp.found  = r_found;
    assign o_thread     = r_got;

endmodule

>>> hw/rtl/delta_timer_queue.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports          Contents
// s_axis    in         tuser, tdata   operation; thread_id, sleep_ticks
// m_axis    out        tuser, tdata   status; expired_thread, expired_valid
//
// One word is worked on at a time by a sequencer around a single shared adder
// and a one-port-write, one-port-read slot memory.
// Push: walk to the insert point, tail shift, insert, fix of the next delta;
// the walk and the shift together cover every slot of the queue.
// Tick: lower the first nonzero delta. Pop: take a due head, then close the gap.
// A result then sits in the output register; the next word is taken while it
// waits, and the sequencer only holds if a second result is ready before it is taken.
// Synchronous active-low reset empties the queue; slot contents are not cleared.

module delta_timer_queue
    import dtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TICK_BITS   = 32,
    parameter int ID_BITS     = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [ID_BITS-1:0] thread_id, then sleep_ticks, then zero fill
    input  logic [((ID_BITS + TICK_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [ID_BITS-1:0] expired_thread, [ID_BITS] expired_valid, then zero fill
    output logic [((ID_BITS + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]           m_axis_tuser
);

    t_dtq_cmd           cmd;
    t_dtq_rsp           rsp;
    logic [ID_BITS-1:0] eng_thread;
    logic               out_free;

    logic               r_m_valid;
    t_status            r_m_status;
    logic [ID_BITS-1:0] r_m_thread;
    logic               r_m_found;

    assign s_axis_tready = rsp.idle;
    assign cmd.start     = s_axis_tvalid & rsp.idle;
    assign cmd.op        = t_op'(s_axis_tuser);
    assign out_free      = !r_m_valid || m_axis_tready;

    dtq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TICK_BITS   (TICK_BITS),
        .ID_BITS     (ID_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_id       (s_axis_tdata[ID_BITS-1:0]),
        .i_ticks    (s_axis_tdata[ID_BITS+TICK_BITS-1:ID_BITS]),
        .i_out_free (out_free),
        .o_rsp      (rsp),
        .o_thread   (eng_thread)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (rsp.done && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (rsp.done && out_free) begin
            r_m_status <= rsp.status;
            r_m_thread <= eng_thread;
            r_m_found  <= rsp.found;
        end
    end

    always_comb begin
        m_axis_tdata              = '0;
        m_axis_tdata[ID_BITS-1:0] = r_m_thread;
        m_axis_tdata[ID_BITS]     = r_m_found;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;

endmodule
